@@ rtl/ptw_pkg.sv @@
// shared types, constants and helpers for the page table walker
`default_nettype none

package ptw_pkg;

    localparam int TABLE_FRAMES_DEF = 64;

    localparam int ROOT_W    = 6;
    localparam int ACTION_W  = 2;
    localparam int INDEX_W   = 9;
    localparam int ENTRY_W   = 64;
    localparam int VA_W      = 48;
    localparam int PA_W      = 52;
    localparam int KIND_W    = 2;
    localparam int FRAME_W   = 40;   // next-table frame field of an entry, bits 51:12

    // action codes
    localparam logic [ACTION_W-1:0] ACT_WRITE     = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TRANSLATE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CHECK     = 2'd2;

    // page size codes
    localparam logic [KIND_W-1:0] KIND_4K = 2'd0;
    localparam logic [KIND_W-1:0] KIND_2M = 2'd1;
    localparam logic [KIND_W-1:0] KIND_1G = 2'd2;

    // entry bit positions
    localparam int ENT_P  = 0;
    localparam int ENT_US = 2;
    localparam int ENT_PS = 7;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK
    } t_state;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [ROOT_W-1:0]   table_frame;
        logic [INDEX_W-1:0]  entry_index;
        logic [ENTRY_W-1:0]  entry_value;
        logic [VA_W-1:0]     virt_addr;
        logic                last_page;
    } t_cmd;

    typedef struct packed {
        logic [PA_W-1:0]   phys_addr;
        logic              mapped;
        logic [KIND_W-1:0] page_kind;
        logic              access_ok;
        logic              bad_table;
    } t_result;

    // table index of a virtual address at a walk level, top level first
    function automatic logic [INDEX_W-1:0] va_index(input logic [VA_W-1:0] va,
                                                    input logic [1:0] lvl);
        logic [INDEX_W-1:0] idx;
        case (lvl)
            2'd0: idx = va[47:39];
            2'd1: idx = va[38:30];
            2'd2: idx = va[29:21];
            default: idx = va[20:12];
        endcase
        return idx;
    endfunction

endpackage

`default_nettype wire

@@ rtl/page_table_walker.sv @@
// four-level page table walker over a local table store
//
// usage: one command is transferred at a rising edge with start high and busy
// low. action write stores entry_value at (table_frame, entry_index); translate
// walks from the root frame to a physical address; check walks one page and
// folds present and user at every level into a running range flag, which is
// set again after a check with last_page high.
// every command gives exactly one result: o_done is high for one cycle with
// o_result valid, and the receiver cannot stall it. the configuration channel
// (i_cfg_valid / o_cfg_ready, always ready) writes the root frame.
// timing: a write or an undefined action finishes in its command cycle, its result
// shows in the next cycle. a walk reads the store once per level through its single
// registered read port: the command cycle issues the top-level read and each
// further level is evaluated in ST_WALK, which issues the next read; a walk holds
// busy until its last read is evaluated, so no command is taken meanwhile, and
// the result follows in the cycle after the last read is evaluated.
// reset: the store is swept to zero one entry per cycle, all TABLE_FRAMES * 512
// entries (32768 at the default), with busy high; the root frame resets to 0.
`default_nettype none

module page_table_walker #(
    parameter int TABLE_FRAMES = ptw_pkg::TABLE_FRAMES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  ptw_pkg::t_cmd                 i_cmd,
    output logic                          o_done,
    output ptw_pkg::t_result              o_result,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ptw_pkg::ROOT_W-1:0]    i_cfg_data
);

    import ptw_pkg::*;

    localparam int DEPTH = TABLE_FRAMES * 512;
    localparam int FW    = $clog2(TABLE_FRAMES);
    localparam int AW    = FW + INDEX_W;

    logic [ENTRY_W-1:0] mem [0:DEPTH-1];

    t_state              r_state, n_state;
    logic [AW-1:0]       r_clr_addr, n_clr_addr;
    logic [1:0]          r_level, n_level;
    logic                r_user, n_user;
    logic [ROOT_W-1:0]   r_root;
    logic                r_range_good, n_range_good;
    logic                r_done, n_done;
    t_result             r_result, n_result;
    t_cmd                r_item;
    logic [ENTRY_W-1:0]  r_rdata;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [ENTRY_W-1:0]  mem_wdata;
    logic [AW-1:0]       mem_raddr;

    logic                accept;
    logic                fin;
    logic [PA_W-1:0]     f_pa;
    logic                f_mapped;
    logic [KIND_W-1:0]   f_kind;
    logic                f_bad;
    logic                f_user;
    logic [ACTION_W-1:0] act;
    logic                last;
    logic [FRAME_W-1:0]  wr_frame;
    logic [FRAME_W-1:0]  root_frame;
    logic [FRAME_W-1:0]  next_frame;
    logic                wr_frame_ok;
    logic                root_ok;
    logic                next_ok;
    logic                rg_after;

    assign accept      = start && (r_state == ST_IDLE);
    assign wr_frame    = FRAME_W'(i_cmd.table_frame);
    assign root_frame  = FRAME_W'(r_root);
    assign next_frame  = r_rdata[51:12];
    assign wr_frame_ok = wr_frame < FRAME_W'(TABLE_FRAMES);
    assign root_ok     = root_frame < FRAME_W'(TABLE_FRAMES);
    assign next_ok     = next_frame < FRAME_W'(TABLE_FRAMES);
    assign act         = (r_state == ST_IDLE) ? i_cmd.action : r_item.action;
    assign last        = (r_state == ST_IDLE) ? i_cmd.last_page : r_item.last_page;

    // table store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept && !fin) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (fin) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        busy        = (r_state != ST_IDLE);
        o_cfg_ready = 1'b1;
        o_done      = r_done;
        o_result    = r_result;
    end

    // store access and walk evaluation
    always_comb begin
        mem_we     = 1'b0;
        mem_waddr  = r_clr_addr;
        mem_wdata  = '0;
        mem_raddr  = '0;
        fin        = 1'b0;
        f_pa       = '0;
        f_mapped   = 1'b0;
        f_kind     = KIND_4K;
        f_bad      = 1'b0;
        f_user     = r_user;
        n_level    = r_level;
        n_user     = r_user;
        n_clr_addr = r_clr_addr;
        case (r_state)
            ST_CLEAR: begin
                mem_we     = 1'b1;
                n_clr_addr = r_clr_addr + AW'(1);
            end
            ST_IDLE: begin
                if (start) begin
                    n_level = 2'd0;
                    n_user  = 1'b1;
                    case (i_cmd.action)
                        ACT_WRITE: begin
                            fin = 1'b1;
                            if (wr_frame_ok) begin
                                mem_we    = 1'b1;
                                mem_waddr = {wr_frame[FW-1:0], i_cmd.entry_index};
                                mem_wdata = i_cmd.entry_value;
                            end else begin
                                f_bad = 1'b1;
                            end
                        end
                        ACT_TRANSLATE, ACT_CHECK: begin
                            if (root_ok) begin
                                mem_raddr = {root_frame[FW-1:0],
                                             va_index(i_cmd.virt_addr, 2'd0)};
                            end else begin
                                fin   = 1'b1;
                                f_bad = 1'b1;
                            end
                        end
                        default: fin = 1'b1;
                    endcase
                end
            end
            ST_WALK: begin
                if (!r_rdata[ENT_P]) begin
                    fin = 1'b1;
                end else begin
                    f_user = r_user & r_rdata[ENT_US];
                    n_user = f_user;
                    if (r_level == 2'd1 && r_rdata[ENT_PS]) begin
                        fin      = 1'b1;
                        f_mapped = 1'b1;
                        f_kind   = KIND_1G;
                        f_pa     = {r_rdata[51:30], r_item.virt_addr[29:0]};
                    end else if (r_level == 2'd2 && r_rdata[ENT_PS]) begin
                        fin      = 1'b1;
                        f_mapped = 1'b1;
                        f_kind   = KIND_2M;
                        f_pa     = {r_rdata[51:21], r_item.virt_addr[20:0]};
                    end else if (r_level == 2'd3) begin
                        fin      = 1'b1;
                        f_mapped = 1'b1;
                        f_kind   = KIND_4K;
                        f_pa     = {r_rdata[51:12], r_item.virt_addr[11:0]};
                    end else if (!next_ok) begin
                        fin   = 1'b1;
                        f_bad = 1'b1;
                    end else begin
                        n_level   = r_level + 2'd1;
                        mem_raddr = {next_frame[FW-1:0],
                                     va_index(r_item.virt_addr, r_level + 2'd1)};
                    end
                end
            end
            default: ;
        endcase
    end

    // result assembly and range flag
    always_comb begin
        n_done       = fin;
        n_result     = r_result;
        n_range_good = r_range_good;
        rg_after     = r_range_good & f_mapped & f_user & ~f_bad;
        if (fin) begin
            n_result           = '0;
            n_result.access_ok = r_range_good;
            n_result.bad_table = f_bad;
            case (act)
                ACT_TRANSLATE: begin
                    n_result.phys_addr = f_pa;
                    n_result.mapped    = f_mapped;
                    n_result.page_kind = f_kind;
                end
                ACT_CHECK: begin
                    n_result.access_ok = rg_after;
                    n_range_good       = last ? 1'b1 : rg_after;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_addr   <= '0;
            r_level      <= 2'd0;
            r_user       <= 1'b1;
            r_root       <= '0;
            r_range_good <= 1'b1;
            r_done       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_level      <= n_level;
            r_user       <= n_user;
            r_range_good <= n_range_good;
            r_done       <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                r_root <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (accept) begin
            r_item <= i_cmd;
        end
    end

endmodule

`default_nettype wire
